// File: src/iag_pkg.sv
// Shared types, constants and helper functions of the im2col address generator.
`default_nettype none
package iag_pkg;

  localparam int unsigned MAX_KERNEL_SIDE = 8;
  localparam int unsigned DIM_BITS = 16;
  localparam int unsigned ROW_W = 24;
  localparam int unsigned SEG_W = 6;
  localparam int unsigned LEN_W = 19;
  localparam int unsigned OFF_W = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned KSIDE_W = (MAX_KERNEL_SIDE > 1) ? $clog2(MAX_KERNEL_SIDE) : 1;
  localparam int unsigned KCNT_W = KSIDE_W + 1;
  localparam int unsigned KOFF_W = DIM_BITS + KSIDE_W;
  localparam int unsigned POS_W = 2 * DIM_BITS + 2;
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DIV_CYCLES = ROW_W / DIV_RADIX_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_CYCLES);
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = 1;
  localparam int unsigned FIFO_CNT_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INPUT_DIMS    = 3'd0,
    REG_OUTPUT_DIMS   = 3'd1,
    REG_PADDING_DIMS  = 3'd2,
    REG_STRIDE_DIMS   = 3'd3,
    REG_DILATION_DIMS = 3'd4,
    REG_KERNEL_DIMS   = 3'd5,
    REG_CHANNEL_COUNT = 3'd6,
    REG_BATCH_COUNT   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [DIM_BITS-1:0] hi;
    logic [DIM_BITS-1:0] wi;
    logic [DIM_BITS-1:0] ho;
    logic [DIM_BITS-1:0] wo;
    logic [DIM_BITS-1:0] ph;
    logic [DIM_BITS-1:0] pw;
    logic [DIM_BITS-1:0] sh;
    logic [DIM_BITS-1:0] sw;
    logic [DIM_BITS-1:0] dh;
    logic [DIM_BITS-1:0] dw;
    logic [KCNT_W-1:0]   kh;
    logic [KCNT_W-1:0]   kw;
    logic [15:0]         ci;
    logic [15:0]         batch;
    logic                row_mode;
  } cfg_t;

  typedef struct packed {
    logic              inb;
    logic [OFF_W-1:0]  nhi;
    logic [POS_W-1:0]  by;
    logic [POS_W-1:0]  bx;
  } job_t;

  function automatic logic [KCNT_W-1:0] clamp_side(input logic [DIM_BITS-1:0] v);
    logic [KCNT_W-1:0] r;
    if (v == '0) begin
      r = KCNT_W'(1);
    end else if (v > DIM_BITS'(MAX_KERNEL_SIDE)) begin
      r = KCNT_W'(MAX_KERNEL_SIDE);
    end else begin
      r = v[KCNT_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [ROW_W+DIM_BITS-1:0] div_step(input logic [ROW_W-1:0] dvd,
                                                        input logic [DIM_BITS-1:0] rem,
                                                        input logic [DIM_BITS-1:0] d);
    logic [ROW_W-1:0]  q;
    logic [DIM_BITS:0] r;
    q = dvd;
    r = {1'b0, rem};
    for (int i = 0; i < DIV_RADIX_BITS; i++) begin
      r = {r[DIM_BITS-1:0], q[ROW_W-1]};
      q = {q[ROW_W-2:0], 1'b0};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[0] = 1'b1;
      end
    end
    return {q, r[DIM_BITS-1:0]};
  endfunction

endpackage
`default_nettype wire

// File: src/im2col_address_generator_unit.sv
// Top level of the im2col address generator: configuration registers, front end, queue, back end.
// Usage:
// Program the eight configuration registers through cfg_we_i, cfg_idx_i and cfg_data_i
// while the block is idle; each write lands at the clock edge with cfg_we_i high.
// Send row indexes on the input channel (in_valid_i, in_stall_o, row_index_i); a
// transfer happens when valid is high and stall is low. Each row index yields kh
// segment results in row mode, or kh*kw tap results otherwise, on the output
// channel (out_valid_o, out_stall_i), with last_o marking the final one.
// Throughput: the back end issues one result per cycle while the receiver does not
// stall and the queue holds a job. The front end runs the radix-16 divider once by the
// output width and once by the output height, then pushes the job into the queue; its
// input buffer can take the next row index while the current one is being divided.
// An input transfer reaches the first result through the input buffer, the divider,
// the job write into the queue and three pipeline stages in the back end.
// Reset clears all control state and loads the register defaults. When the receiver
// stalls, the output register holds, the back end freezes, the two-entry queue fills
// and then the front end and the input channel stall in turn.
`default_nettype none
module im2col_address_generator_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [iag_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [iag_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [iag_pkg::ROW_W-1:0]      row_index_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [iag_pkg::SEG_W-1:0]           segment_index_o,
  output logic                                is_pad_o,
  output logic [iag_pkg::OFF_W-1:0]           element_offset_o,
  output logic [iag_pkg::LEN_W-1:0]           segment_length_o,
  output logic                                last_o
);
  import iag_pkg::*;

  logic [31:0] input_dims_q, output_dims_q, padding_dims_q, stride_dims_q, dilation_dims_q;
  logic [19:0] kernel_dims_q;
  logic [15:0] channel_count_q, batch_count_q;
  cfg_t        cfg;
  job_t        push_job, head_job;
  logic        push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      input_dims_q    <= 32'h0001_0001;
      output_dims_q   <= 32'h0001_0001;
      padding_dims_q  <= '0;
      stride_dims_q   <= 32'h0001_0001;
      dilation_dims_q <= 32'h0001_0001;
      kernel_dims_q   <= 20'h1_0001;
      channel_count_q <= 16'd1;
      batch_count_q   <= 16'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_INPUT_DIMS:    input_dims_q    <= cfg_data_i;
        REG_OUTPUT_DIMS:   output_dims_q   <= cfg_data_i;
        REG_PADDING_DIMS:  padding_dims_q  <= cfg_data_i;
        REG_STRIDE_DIMS:   stride_dims_q   <= cfg_data_i;
        REG_DILATION_DIMS: dilation_dims_q <= cfg_data_i;
        REG_KERNEL_DIMS:   kernel_dims_q   <= cfg_data_i[19:0];
        REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[15:0];
        REG_BATCH_COUNT:   batch_count_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.hi       = input_dims_q[16+:DIM_BITS];
    cfg.wi       = input_dims_q[0+:DIM_BITS];
    cfg.ho       = output_dims_q[16+:DIM_BITS];
    cfg.wo       = output_dims_q[0+:DIM_BITS];
    cfg.ph       = padding_dims_q[16+:DIM_BITS];
    cfg.pw       = padding_dims_q[0+:DIM_BITS];
    cfg.sh       = stride_dims_q[16+:DIM_BITS];
    cfg.sw       = stride_dims_q[0+:DIM_BITS];
    cfg.dh       = dilation_dims_q[16+:DIM_BITS];
    cfg.dw       = dilation_dims_q[0+:DIM_BITS];
    cfg.kh       = clamp_side(DIM_BITS'(kernel_dims_q[19:16]));
    cfg.kw       = clamp_side(kernel_dims_q[0+:DIM_BITS]);
    cfg.ci       = channel_count_q;
    cfg.batch    = batch_count_q;
    cfg.row_mode = (cfg.ph == '0) && (cfg.pw == '0)
                && (cfg.dh == DIM_BITS'(1)) && (cfg.dw == DIM_BITS'(1));
  end

  iag_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .row_index_i (row_index_i),
    .push_o      (push),
    .job_o       (push_job),
    .full_i      (full)
  );

  iag_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_job),
    .empty_o     (empty)
  );

  iag_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .job_i            (head_job),
    .empty_i          (empty),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .segment_index_o  (segment_index_o),
    .is_pad_o         (is_pad_o),
    .element_offset_o (element_offset_o),
    .segment_length_o (segment_length_o),
    .last_o           (last_o)
  );

endmodule
`default_nettype wire

// File: src/iag_fifo.sv
// Two-entry job queue between the index splitter and the segment sequencer.
`default_nettype none
module iag_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  iag_pkg::job_t       push_data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output iag_pkg::job_t       head_o,
  output logic                empty_o
);
  import iag_pkg::*;

  job_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule
`default_nettype wire

// File: src/iag_front.sv
// Front end: accepts row indexes, splits them into batch, row and column, builds jobs.
`default_nettype none
module iag_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  iag_pkg::cfg_t                   cfg_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [iag_pkg::ROW_W-1:0]  row_index_i,
  output logic                            push_o,
  output iag_pkg::job_t                   job_o,
  input  wire logic                       full_i
);
  import iag_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIV_W = 4'b0010,
    ST_DIV_H = 4'b0100,
    ST_PUSH  = 4'b1000
  } state_e;

  state_e                state_q, state_d;
  logic                  buf_v_q, buf_v_d;
  logic [ROW_W-1:0]      buf_row_q;
  logic [ROW_W-1:0]      dvd_q, dvd_d;
  logic [DIM_BITS-1:0]   rem_q, rem_d;
  logic [DIM_BITS-1:0]   w_q, w_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [ROW_W+DIM_BITS-1:0] step;
  logic                  start;
  logic [2*DIM_BITS-1:0] hs, ws;

  assign in_stall_o = buf_v_q;
  assign step = div_step(dvd_q, rem_q, (state_q == ST_DIV_H) ? cfg_i.ho : cfg_i.wo);

  assign hs = rem_q * cfg_i.sh;
  assign ws = w_q * cfg_i.sw;
  assign job_o.inb = (cfg_i.wo != '0) && (cfg_i.ho != '0) && (dvd_q < ROW_W'(cfg_i.batch));
  assign job_o.nhi = OFF_W'(dvd_q[DIM_BITS-1:0]) * OFF_W'(cfg_i.hi);
  assign job_o.by  = {2'b00, hs} - POS_W'(cfg_i.ph);
  assign job_o.bx  = {2'b00, ws} - POS_W'(cfg_i.pw);
  assign push_o    = (state_q == ST_PUSH) && !full_i;

  always_comb begin
    state_d = state_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    w_d     = w_q;
    cnt_d   = cnt_q;
    start   = 1'b0;
    unique case (state_q)
      ST_IDLE: start = buf_v_q;
      ST_DIV_W: begin
        dvd_d = step[ROW_W+DIM_BITS-1:DIM_BITS];
        rem_d = step[DIM_BITS-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          w_d     = step[DIM_BITS-1:0];
          rem_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV_H;
        end
      end
      ST_DIV_H: begin
        dvd_d = step[ROW_W+DIM_BITS-1:DIM_BITS];
        rem_d = step[DIM_BITS-1:0];
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          cnt_d   = '0;
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!full_i) begin
          state_d = ST_IDLE;
          start   = buf_v_q;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (start) begin
      dvd_d   = buf_row_q;
      rem_d   = '0;
      cnt_d   = '0;
      state_d = ST_DIV_W;
    end
  end

  always_comb begin
    buf_v_d = buf_v_q;
    if (start) buf_v_d = 1'b0;
    if (in_valid_i && !in_stall_o) buf_v_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      buf_v_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      buf_v_q <= buf_v_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) buf_row_q <= row_index_i;
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    w_q   <= w_d;
  end

endmodule
`default_nettype wire

// File: src/iag_back.sv
// Back end: walks the kernel segments of each job and computes offsets in a short pipeline.
`default_nettype none
module iag_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  iag_pkg::cfg_t                   cfg_i,
  input  iag_pkg::job_t                   job_i,
  input  wire logic                       empty_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [iag_pkg::SEG_W-1:0]       segment_index_o,
  output logic                            is_pad_o,
  output logic [iag_pkg::OFF_W-1:0]       element_offset_o,
  output logic [iag_pkg::LEN_W-1:0]       segment_length_o,
  output logic                            last_o
);
  import iag_pkg::*;

  logic                en, issue, x_wrap, seg_last;
  logic [SEG_W-1:0]    k_q;
  logic [KSIDE_W-1:0]  ky_q, kx_q;
  logic [KOFF_W-1:0]   yoff_q, xoff_q;

  logic                s1_v_q, s1_last_q, s1_inb_q;
  logic [SEG_W-1:0]    s1_k_q;
  logic [POS_W-1:0]    s1_y_q, s1_x_q;
  logic [OFF_W-1:0]    s1_nhi_q;

  logic                s2_v_q, s2_last_q, s2_pad_q;
  logic [SEG_W-1:0]    s2_k_q;
  logic [OFF_W-1:0]    s2_t_q, s2_x_q;

  logic                s1_pad;
  logic [OFF_W+DIM_BITS-1:0] t_full, off_full;
  logic [KCNT_W+15:0]  row_len;

  assign en       = !(out_valid_o && out_stall_i);
  assign issue    = en && !empty_i;
  assign x_wrap   = cfg_i.row_mode || (kx_q == KSIDE_W'(cfg_i.kw - 1'b1));
  assign seg_last = x_wrap && (ky_q == KSIDE_W'(cfg_i.kh - 1'b1));
  assign pop_o    = issue && seg_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= '0;
      ky_q   <= '0;
      kx_q   <= '0;
      yoff_q <= '0;
      xoff_q <= '0;
    end else if (issue) begin
      if (seg_last) begin
        k_q    <= '0;
        ky_q   <= '0;
        kx_q   <= '0;
        yoff_q <= '0;
        xoff_q <= '0;
      end else begin
        k_q <= k_q + 1'b1;
        if (x_wrap) begin
          kx_q   <= '0;
          xoff_q <= '0;
          ky_q   <= ky_q + 1'b1;
          yoff_q <= yoff_q + KOFF_W'(cfg_i.dh);
        end else begin
          kx_q   <= kx_q + 1'b1;
          xoff_q <= xoff_q + KOFF_W'(cfg_i.dw);
        end
      end
    end
  end

  assign s1_pad = !s1_inb_q || s1_y_q[POS_W-1] || s1_x_q[POS_W-1]
               || (s1_y_q >= POS_W'(cfg_i.hi)) || (s1_x_q >= POS_W'(cfg_i.wi));
  assign t_full   = (s1_nhi_q + s1_y_q[OFF_W-1:0]) * cfg_i.wi;
  assign off_full = (s2_t_q + s2_x_q) * cfg_i.ci;
  assign row_len  = cfg_i.kw * cfg_i.ci;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en) begin
      s1_v_q      <= !empty_i;
      s2_v_q      <= s1_v_q;
      out_valid_o <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_k_q    <= k_q;
      s1_last_q <= seg_last;
      s1_inb_q  <= job_i.inb;
      s1_y_q    <= job_i.by + POS_W'(yoff_q);
      s1_x_q    <= job_i.bx + POS_W'(xoff_q);
      s1_nhi_q  <= job_i.nhi;
      s2_k_q    <= s1_k_q;
      s2_last_q <= s1_last_q;
      s2_pad_q  <= s1_pad;
      s2_t_q    <= t_full[OFF_W-1:0];
      s2_x_q    <= s1_x_q[OFF_W-1:0];
      segment_index_o  <= s2_k_q;
      last_o           <= s2_last_q;
      is_pad_o         <= s2_pad_q;
      element_offset_o <= s2_pad_q ? '0 : off_full[OFF_W-1:0];
    end
  end

  assign segment_length_o = cfg_i.row_mode ? row_len[LEN_W-1:0] : LEN_W'(cfg_i.ci);

endmodule
`default_nettype wire

// File: src/iag_checker.sv
// Port-level checker for the im2col address generator and its bind.
`default_nettype none
module iag_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [iag_pkg::SEG_W-1:0]      segment_index_o,
  input wire logic                           is_pad_o,
  input wire logic [iag_pkg::OFF_W-1:0]      element_offset_o,
  input wire logic                           last_o
);
  import iag_pkg::*;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output transfer dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(segment_index_o) && $stable(element_offset_o))
    else $error("output payload changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_pad_o |-> element_offset_o == '0)
    else $error("padding segment with nonzero offset");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (segment_index_o == SEG_W'(MAX_KERNEL_SIDE * MAX_KERNEL_SIDE - 1)) |-> last_o)
    else $error("segment count exceeds kernel size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_o ##1 out_valid_o |-> segment_index_o != '0)
    else $error("row restarted before its last segment");

endmodule

bind im2col_address_generator_unit iag_checker u_iag_checker (.*);
`default_nettype wire

// File: bench/im2col_address_generator_unit_test.sv
// Self-checking testbench for the im2col address generator: predicted segment stream vs. DUT.
`timescale 1ns / 1ps
module im2col_address_generator_unit_test;
  import iag_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned SETTLE_CYCLES = 30;

  typedef struct {
    bit [SEG_W-1:0] seg;
    bit             pad;
    bit [OFF_W-1:0] off;
    bit [LEN_W-1:0] len;
    bit             last;
  } segment_t;

  class segment_scoreboard;
    bit [31:0] regs [8];
    segment_t  pending_q [$];
    int        errors;
    int        rows_seen;
    int        segs_seen;

    function new();
      regs[REG_INPUT_DIMS]    = 32'h0001_0001;
      regs[REG_OUTPUT_DIMS]   = 32'h0001_0001;
      regs[REG_PADDING_DIMS]  = 32'h0;
      regs[REG_STRIDE_DIMS]   = 32'h0001_0001;
      regs[REG_DILATION_DIMS] = 32'h0001_0001;
      regs[REG_KERNEL_DIMS]   = 32'h0001_0001;
      regs[REG_CHANNEL_COUNT] = 32'd1;
      regs[REG_BATCH_COUNT]   = 32'd1;
    endfunction

    function void write_reg(cfg_reg_e idx, bit [31:0] data);
      case (idx) inside
        REG_KERNEL_DIMS: regs[idx] = data & 32'h000F_FFFF;
        REG_CHANNEL_COUNT, REG_BATCH_COUNT: regs[idx] = data & 32'h0000_FFFF;
        default: regs[idx] = data;
      endcase
    endfunction

    function longint unsigned clamp(longint unsigned v);
      if (v < 1) return 1;
      if (v > MAX_KERNEL_SIDE) return MAX_KERNEL_SIDE;
      return v;
    endfunction

    function void note_row(bit [ROW_W-1:0] row);
      longint unsigned hi, wi, ho, wo, ph, pw, sh, sw, dh, dw, kh, kw, ci;
      longint unsigned total, segs, len, n, h, w, plane, rem, ky, kx, off;
      longint y, x;
      bit row_mode, in_range;
      segment_t s;
      hi = regs[REG_INPUT_DIMS][31:16];    wi = regs[REG_INPUT_DIMS][15:0];
      ho = regs[REG_OUTPUT_DIMS][31:16];   wo = regs[REG_OUTPUT_DIMS][15:0];
      ph = regs[REG_PADDING_DIMS][31:16];  pw = regs[REG_PADDING_DIMS][15:0];
      sh = regs[REG_STRIDE_DIMS][31:16];   sw = regs[REG_STRIDE_DIMS][15:0];
      dh = regs[REG_DILATION_DIMS][31:16]; dw = regs[REG_DILATION_DIMS][15:0];
      kh = clamp(regs[REG_KERNEL_DIMS][19:16]);
      kw = clamp(regs[REG_KERNEL_DIMS][15:0]);
      ci = regs[REG_CHANNEL_COUNT][15:0];
      total = longint'(regs[REG_BATCH_COUNT][15:0]) * ho * wo;
      row_mode = (ph == 0 && pw == 0 && dh == 1 && dw == 1);
      segs = row_mode ? kh : kh * kw;
      len = row_mode ? kw * ci : ci;
      in_range = row < total;
      n = 0; h = 0; w = 0;
      if (in_range) begin
        plane = ho * wo;
        n = row / plane;
        rem = row - n * plane;
        h = rem / wo;
        w = rem - h * wo;
      end
      rows_seen++;
      for (longint unsigned k = 0; k < segs; k++) begin
        ky = row_mode ? k : k / kw;
        kx = row_mode ? 0 : k % kw;
        y = longint'(h * sh + ky * dh) - longint'(ph);
        x = longint'(w * sw + kx * dw) - longint'(pw);
        s.seg = k[SEG_W-1:0];
        s.len = len[LEN_W-1:0];
        s.last = (k + 1 == segs);
        if (in_range && y >= 0 && x >= 0 && y < longint'(hi) && x < longint'(wi)) begin
          off = n * hi * wi * ci + longint'(y) * wi * ci + longint'(x) * ci;
          s.pad = 1'b0;
          s.off = off[31:0];
        end else begin
          s.pad = 1'b1;
          s.off = '0;
        end
        pending_q.push_back(s);
      end
    endfunction

    function void check_result(bit [SEG_W-1:0] seg, bit pad, bit [OFF_W-1:0] off,
                               bit [LEN_W-1:0] len, bit last);
      segment_t e;
      segs_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("mismatch: unexpected segment %0d off %h", seg, off);
        return;
      end
      e = pending_q.pop_front();
      if (e.seg != seg || e.pad != pad || e.off != off || e.len != len || e.last != last) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch: exp seg %0d pad %0b off %h len %0d last %0b",
                   e.seg, e.pad, e.off, e.len, e.last);
          $display("          got seg %0d pad %0b off %h len %0d last %0b",
                   seg, pad, off, len, last);
        end
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [ROW_W-1:0]      row_index_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [SEG_W-1:0]      segment_index_o;
  logic                  is_pad_o;
  logic [OFF_W-1:0]      element_offset_o;
  logic [LEN_W-1:0]      segment_length_o;
  logic                  last_o;

  segment_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int cycles = 0;
  int phases = 0;

  im2col_address_generator_unit dut (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(segment_index_o, is_pad_o, element_offset_o, segment_length_o, last_o);
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i = 1'b0;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  task automatic send_row(bit [ROW_W-1:0] row);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    row_index_i = row;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_row(row);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic program_regs(bit [31:0] in_d, bit [31:0] out_d, bit [31:0] pad_d,
                              bit [31:0] str_d, bit [31:0] dil_d, bit [31:0] ker_d,
                              bit [31:0] ci_d, bit [31:0] bat_d);
    bit [31:0] vals [8];
    cfg_reg_e idx;
    vals = '{in_d, out_d, pad_d, str_d, dil_d, ker_d, ci_d, bat_d};
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_e'(i);
      @(negedge clk_i);
      cfg_we_i = 1'b1;
      cfg_idx_i = idx;
      cfg_data_i = vals[i];
      sb.write_reg(idx, vals[i]);
    end
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    phases++;
  endtask

  initial begin
    bit [15:0] hi, wi, ho, wo, kh, kw, ci, bat;
    int unsigned total;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    send_row(24'd0);
    send_row(24'd1);
    send_row(24'hFF_FFFF);

    program_regs(32'h0005_0006, 32'h0005_0006, 32'h0001_0001, 32'h0001_0001,
                 32'h0001_0001, 32'h0003_0003, 32'd3, 32'd2);
    send_row(24'd0);
    send_row(24'd5);
    send_row(24'd29);
    send_row(24'd30);
    send_row(24'd59);
    send_row(24'd60);

    program_regs(32'h0009_000B, 32'h0004_0004, 32'h0, 32'h0002_0002,
                 32'h0001_0001, 32'h0003_0004, 32'd16, 32'd3);
    send_row(24'd0);
    send_row(24'd15);
    send_row(24'd47);
    send_row(24'd48);

    program_regs('1, '1, '1, '1, '1, '1, '1, '1);
    send_row(24'hFF_FFFF);
    send_row(24'd0);
    send_row(24'hAB_CDEF);
    send_row(24'h54_3210);

    program_regs(32'h0004_0004, 32'h0000_0004, 32'h0, 32'h0001_0001,
                 32'h0001_0001, 32'h0, 32'd0, 32'd1);
    send_row(24'd0);
    program_regs(32'h0004_0004, 32'h0004_0004, 32'h0, 32'h0001_0001,
                 32'h0001_0001, 32'hFFF0_0000, 32'd0, 32'd1);
    send_row(24'd0);
    send_row(24'd3);

    for (int p = 0; p < 10; p++) begin
      hi = $urandom_range(1, 12); wi = $urandom_range(1, 12);
      ho = $urandom_range(1, 8);  wo = $urandom_range(1, 8);
      kh = $urandom_range(1, 4);  kw = $urandom_range(1, 4);
      ci = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
      bat = $urandom_range(1, 4);
      total = bat * ho * wo;
      if (p == 9) calm = 1'b1;
      if (p == 4) begin
        program_regs($urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom);
        total = 32'h00FF_FFFF;
      end else if ($urandom_range(0, 9) < 4) begin
        program_regs({hi, wi}, {ho, wo}, 32'h0,
                     {16'($urandom_range(1, 3)), 16'($urandom_range(1, 3))}, 32'h0001_0001,
                     {12'($urandom), kh[3:0], kw}, ci, bat);
      end else begin
        program_regs({hi, wi}, {ho, wo},
                     {16'($urandom_range(0, 2)), 16'($urandom_range(0, 2))},
                     {16'($urandom_range(1, 3)), 16'($urandom_range(1, 3))},
                     {16'($urandom_range(1, 2)), 16'($urandom_range(1, 2))},
                     {12'($urandom), kh[3:0], kw}, ci, bat);
      end
      if (p == 2) hold_req = 1'b1;
      for (int i = 0; i < 20; i++) begin
        if (p == 6 && i == 10) drain();
        if ($urandom_range(0, 9) == 0) send_row(ROW_W'($urandom));
        else send_row(ROW_W'($urandom_range(0, total + 3)));
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("checked %0d row indexes and %0d segment results across %0d register settings",
             sb.rows_seen, sb.segs_seen, phases);
    $display("covered padding/tap and row modes, kernel clamping, zero channels, rows past batch");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
